>>> design/fcf_pkg.sv
`default_nettype none
package fcf_pkg;

  typedef struct packed {
    logic       op;
    logic [2:0] addr;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } out_item_t;

  typedef logic [4:0] cmd_code_t;

  // command state word: parameter bytes expected, results queued, dma, busy, command
  typedef struct packed {
    logic      bytes;
    logic      queue;
    logic      dma;
    logic      busy;
    cmd_code_t code;
  } cmd_state_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] REG_STATUS_A = 3'd0;
  localparam logic [2:0] REG_UNUSED   = 3'd1;
  localparam logic [2:0] REG_DOR      = 3'd2;
  localparam logic [2:0] REG_TAPE     = 3'd3;
  localparam logic [2:0] REG_MSR      = 3'd4;
  localparam logic [2:0] REG_FIFO     = 3'd5;
  localparam logic [2:0] REG_NONE     = 3'd6;
  localparam logic [2:0] REG_RATE     = 3'd7;

  localparam cmd_code_t CMD_NONE        = 5'h00;
  localparam cmd_code_t CMD_SPECIFY     = 5'h03;
  localparam cmd_code_t CMD_SENSE_DRIVE = 5'h04;
  localparam cmd_code_t CMD_READ_DATA   = 5'h06;
  localparam cmd_code_t CMD_RECAL       = 5'h07;
  localparam cmd_code_t CMD_SENSE_INT   = 5'h08;
  localparam cmd_code_t CMD_READ_ID     = 5'h0a;
  localparam cmd_code_t CMD_SEEK        = 5'h0f;
  localparam cmd_code_t CMD_VERSION     = 5'h10;
  localparam cmd_code_t CMD_CONFIGURE   = 5'h13;

  localparam logic [7:0] MSR_QUEUED     = 8'hd0;
  localparam logic [7:0] MSR_READY      = 8'h80;
  localparam logic [7:0] MSR_BUSY       = 8'h10;
  localparam logic [7:0] MSR_DMA        = 8'h20;
  localparam logic [7:0] MSR_PARAMS     = 8'h40;
  localparam logic [7:0] VERSION_BYTE   = 8'h90;
  localparam logic [7:0] ST3_BASE       = 8'h28;
  localparam logic [7:0] ST0_SEEK_END   = 8'h20;
  localparam logic [7:0] ST0_HEAD       = 8'h04;
  localparam logic [7:0] TAPE_BYTE      = 8'h80;
  localparam logic [7:0] RATE_BYTE      = 8'h02;
  localparam logic [7:0] SIZE_CODE      = 8'h02;
  localparam logic [7:0] IRQ_PENDING    = 8'h80;

endpackage
`default_nettype wire

>>> design/fcf_in_reg.sv
`default_nettype none
module fcf_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fcf_pkg::in_item_t in_data,
  input  wire logic             out_ready,
  output logic                  fire,
  output fcf_pkg::in_item_t     item
);
  import fcf_pkg::*;

  logic     valid;
  logic     valid_next;
  in_item_t data;

  assign fire     = valid && out_ready;
  assign in_stall = valid && !out_ready;
  assign item     = data;

  always_comb begin
    valid_next = valid;
    if (in_valid && !in_stall) begin
      valid_next = 1'b1;
    end else if (fire) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (in_valid && !in_stall) begin
      data <= in_data;
    end
  end

endmodule
`default_nettype wire

>>> design/fcf_core.sv
`default_nettype none
module fcf_core #(
  parameter int CMD_STORE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire fcf_pkg::in_item_t item,
  output fcf_pkg::out_item_t     result
);
  import fcf_pkg::*;

  localparam int IDX_W = $clog2(CMD_STORE_DEPTH);

  cmd_state_t cmd_state, cmd_state_next;
  logic [3:0] params_left, params_left_next;
  logic [2:0] results_left, results_left_next;
  logic [7:0] store [CMD_STORE_DEPTH];
  logic [7:0] store_next [CMD_STORE_DEPTH];
  logic [7:0] head_pos, head_pos_next;
  logic [7:0] track_pos, track_pos_next;
  logic [7:0] sector_pos, sector_pos_next;
  logic [7:0] end_sector, end_sector_next;
  logic [7:0] status_a_reg, status_a_reg_next;
  logic [7:0] dor_reg, dor_reg_next;
  logic       irq_active, irq_active_next;
  logic       seek_done, seek_done_next;
  logic       in_reset, in_reset_next;
  logic       high_density, high_density_next;
  logic [7:0] rd;

  always_comb begin
    logic       wr;
    logic [7:0] wd;
    logic [3:0] pl_dec;
    logic [2:0] rl_dec;
    logic       sig_irq;
    logic       do_load;
    logic [7:0] load_sec;
    logic [7:0] s0, s1, s2, s4, s5, s6;

    wr = (item.op == OP_WRITE);
    wd = item.wdata;
    pl_dec = params_left - 4'd1;
    rl_dec = results_left - 3'd1;
    sig_irq = 1'b0;
    do_load = 1'b0;
    load_sec = '0;
    s0 = '0; s1 = '0; s2 = '0; s4 = '0; s5 = '0; s6 = '0;

    cmd_state_next    = cmd_state;
    params_left_next  = params_left;
    results_left_next = results_left;
    store_next        = store;
    head_pos_next     = head_pos;
    track_pos_next    = track_pos;
    sector_pos_next   = sector_pos;
    end_sector_next   = end_sector;
    status_a_reg_next = status_a_reg;
    dor_reg_next      = dor_reg;
    irq_active_next   = irq_active;
    seek_done_next    = seek_done;
    in_reset_next     = in_reset;
    high_density_next = high_density;
    rd = '0;

    unique case (item.addr)
      REG_RATE: begin
        if (wr) begin
          high_density_next = (wd[1:0] == 2'b11);
        end else begin
          rd = RATE_BYTE;
        end
      end
      REG_NONE: begin
      end
      REG_STATUS_A: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
        if (wr) begin
          status_a_reg_next = wd;
        end else begin
          rd = status_a_reg | (irq_active ? IRQ_PENDING : 8'h00);
          status_a_reg_next = status_a_reg & ~IRQ_PENDING;
          cmd_state_next = cmd_state;
        end
      end
      REG_UNUSED: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
      end
      REG_DOR: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
        if (wr) begin
          dor_reg_next = wd;
          params_left_next = '0;
          if (wd[2]) begin
            // leaving reset raises the interrupt
            if (in_reset) begin
              sig_irq = 1'b1;
            end else begin
              cmd_state_next = cmd_state;
            end
            in_reset_next = 1'b0;
          end else begin
            in_reset_next = 1'b1;
          end
        end else begin
          cmd_state_next = cmd_state;
        end
      end
      REG_TAPE: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
        if (!wr) begin
          rd = TAPE_BYTE;
        end
      end
      REG_MSR: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
        if (!wr) begin
          if (cmd_state.queue) begin
            rd = MSR_QUEUED;
          end else begin
            rd = MSR_READY
               | (cmd_state.busy ? MSR_BUSY : (cmd_state.bytes ? MSR_PARAMS : 8'h00))
               | (cmd_state.dma ? MSR_DMA : 8'h00);
          end
          cmd_state_next = cmd_state;
          cmd_state_next.busy = 1'b0;
          cmd_state_next.dma  = 1'b0;
        end
      end
      REG_FIFO: begin
        irq_active_next = 1'b0;
        cmd_state_next  = '0;
        if (wr && cmd_state.bytes) begin
          params_left_next = pl_dec;
          // a parameter index beyond the store is dropped
          if (32'(pl_dec) < CMD_STORE_DEPTH) begin
            store_next[pl_dec[IDX_W-1:0]] = wd;
          end
          s0 = store_next[0]; s1 = store_next[1]; s2 = store_next[2];
          s4 = store_next[4]; s5 = store_next[5]; s6 = store_next[6];
          if (pl_dec != 4'd0) begin
            cmd_state_next = cmd_state;
            cmd_state_next.busy = 1'b1;
          end else begin
            unique case (cmd_state.code)
              CMD_SEEK: begin
                seek_done_next = 1'b1;
                head_pos_next = {7'd0, s1[1]};
                track_pos_next = s0;
                store_next[1] = ST0_SEEK_END;
                store_next[0] = s0;
                results_left_next = '0;
                cmd_state_next.busy = 1'b1;
                sig_irq = 1'b1;
              end
              CMD_RECAL: begin
                seek_done_next = 1'b1;
                head_pos_next = '0;
                track_pos_next = '0;
                results_left_next = '0;
                cmd_state_next.code = CMD_RECAL;
                sig_irq = 1'b1;
              end
              CMD_SPECIFY: begin
                results_left_next = '0;
                cmd_state_next.busy = 1'b1;
                dor_reg_next[3] = s1[0];
              end
              CMD_SENSE_DRIVE: begin
                results_left_next = 3'd1;
                store_next[0] = ST3_BASE | {5'd0, s0[2:0]};
                cmd_state_next.code = CMD_SENSE_DRIVE;
                cmd_state_next.queue = 1'b1;
              end
              CMD_CONFIGURE: begin
                results_left_next = '0;
              end
              CMD_READ_ID: begin
                head_pos_next = {7'd0, s0[2]};
                cmd_state_next.code = CMD_READ_ID;
                cmd_state_next.queue = 1'b1;
                do_load = 1'b1;
                load_sec = 8'd1;
                sig_irq = 1'b1;
              end
              CMD_READ_DATA: begin
                seek_done_next = 1'b1;
                cmd_state_next.code = CMD_READ_DATA;
                cmd_state_next.queue = 1'b1;
                cmd_state_next.dma = 1'b1;
                track_pos_next = s6;
                head_pos_next = s5;
                sector_pos_next = s4;
                end_sector_next = s2;
                do_load = 1'b1;
                load_sec = s4;
                sig_irq = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end else if (wr) begin
          unique case (wd[4:0])
            CMD_SPECIFY, CMD_SEEK: begin
              params_left_next = 4'd2;
              cmd_state_next = '{bytes: 1'b1, queue: 1'b0, dma: 1'b0, busy: 1'b1,
                                 code: wd[4:0]};
            end
            CMD_SENSE_DRIVE, CMD_RECAL, CMD_READ_ID: begin
              params_left_next = 4'd1;
              cmd_state_next = '{bytes: 1'b1, queue: 1'b0, dma: 1'b0, busy: 1'b1,
                                 code: wd[4:0]};
            end
            CMD_CONFIGURE: begin
              params_left_next = 4'd3;
              cmd_state_next = '{bytes: 1'b1, queue: 1'b0, dma: 1'b0, busy: 1'b1,
                                 code: wd[4:0]};
            end
            CMD_READ_DATA: begin
              params_left_next = 4'd8;
              cmd_state_next = '{bytes: 1'b1, queue: 1'b0, dma: 1'b0, busy: 1'b1,
                                 code: wd[4:0]};
            end
            CMD_SENSE_INT: begin
              params_left_next = '0;
              results_left_next = 3'd2;
              store_next[1] = ST0_SEEK_END;
              store_next[0] = track_pos;
              seek_done_next = 1'b0;
              cmd_state_next = '{bytes: 1'b0, queue: 1'b1, dma: 1'b0, busy: 1'b1,
                                 code: CMD_NONE};
            end
            CMD_VERSION: begin
              results_left_next = 3'd1;
              store_next[0] = VERSION_BYTE;
              cmd_state_next = '{bytes: 1'b0, queue: 1'b1, dma: 1'b0, busy: 1'b0,
                                 code: CMD_VERSION};
              sig_irq = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (cmd_state.queue) begin
          // result bytes are read from the top index down
          results_left_next = rl_dec;
          rd = store[IDX_W'(rl_dec)];
          if (rl_dec != 3'd0) begin
            cmd_state_next = cmd_state;
          end else if (cmd_state.code == CMD_READ_DATA) begin
            cmd_state_next = '{bytes: 1'b0, queue: 1'b0, dma: 1'b1, busy: 1'b1,
                               code: CMD_READ_DATA};
          end else if (cmd_state.code == CMD_SEEK) begin
            cmd_state_next.busy = 1'b1;
          end
        end
      end
    endcase

    if (do_load) begin
      results_left_next = 3'd7;
      store_next[6] = (seek_done_next ? ST0_SEEK_END : 8'h00)
                    | ((head_pos_next != 8'd0) ? ST0_HEAD : 8'h00);
      store_next[5] = '0;
      store_next[4] = '0;
      store_next[3] = track_pos_next;
      store_next[2] = head_pos_next;
      store_next[1] = load_sec;
      store_next[0] = SIZE_CODE;
    end

    if (sig_irq) begin
      if (dor_reg_next[3]) begin
        irq_active_next = 1'b1;
      end
      status_a_reg_next = status_a_reg_next | IRQ_PENDING;
    end
  end

  assign result.rdata = rd;
  assign result.irq   = irq_active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_state    <= '0;
      params_left  <= '0;
      results_left <= '0;
      for (int i = 0; i < CMD_STORE_DEPTH; i++) begin
        store[i] <= '0;
      end
      head_pos     <= '0;
      track_pos    <= '0;
      sector_pos   <= '0;
      end_sector   <= '0;
      status_a_reg <= '0;
      dor_reg      <= '0;
      irq_active   <= 1'b0;
      seek_done    <= 1'b0;
      in_reset     <= 1'b0;
      high_density <= 1'b1;
    end else if (fire) begin
      cmd_state    <= cmd_state_next;
      params_left  <= params_left_next;
      results_left <= results_left_next;
      store        <= store_next;
      head_pos     <= head_pos_next;
      track_pos    <= track_pos_next;
      sector_pos   <= sector_pos_next;
      end_sector   <= end_sector_next;
      status_a_reg <= status_a_reg_next;
      dor_reg      <= dor_reg_next;
      irq_active   <= irq_active_next;
      seek_done    <= seek_done_next;
      in_reset     <= in_reset_next;
      high_density <= high_density_next;
    end
  end

`ifndef SYNTHESIS
  a_irq_needs_dor: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_active) |-> dor_reg[3])
    else $error("interrupt raised with dor interrupt enable clear");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_WRITE |-> result.rdata == 8'h00)
    else $error("write item returned non-zero data");

  a_none_reg_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && item.addr == REG_NONE |=> $stable(cmd_state) && $stable(irq_active)
      && $stable(results_left))
    else $error("access to undecoded offset changed state");

  a_irq_follows_line: assert property (@(posedge clk) disable iff (rst)
    fire |=> irq_active == $past(result.irq))
    else $error("stored interrupt level differs from reported level");
`endif

endmodule
`default_nettype wire

>>> design/fcf_out_reg.sv
`default_nettype none
module fcf_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire fcf_pkg::out_item_t result,
  output logic                    out_ready,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fcf_pkg::out_item_t      out_data
);
  import fcf_pkg::*;

  logic      valid;
  logic      valid_next;
  out_item_t data;

  assign out_ready = !valid || !out_stall;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    valid_next = valid;
    if (fire) begin
      valid_next = 1'b1;
    end else if (!out_stall) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= result;
    end
  end

endmodule
`default_nettype wire

>>> design/floppy_controller_command_fifo.sv
// an accepted item is held in the input register, then its result is registered onto out_data
// throughput: one item per cycle unless the output stalls; the state updates once per item
// a stalled output holds its result while one further item waits in the input register
// reset (rst, synchronous, active high) empties both registers, clears the controller state
// and the command byte store, and sets high density
`default_nettype none
module floppy_controller_command_fifo #(
  parameter int CMD_STORE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fcf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fcf_pkg::out_item_t      out_data
);
  import fcf_pkg::*;

  logic      out_ready;
  logic      fire;
  in_item_t  item;
  out_item_t result;

  fcf_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_ready (out_ready),
    .fire      (fire),
    .item      (item)
  );

  fcf_core #(
    .CMD_STORE_DEPTH (CMD_STORE_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  fcf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
  import fcf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  always #5 clk = ~clk;

  floppy_controller_command_fifo DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // one bus access, and the result typed in by hand where it is obvious
  typedef struct packed {
    in_item_t  acc;
    logic      typed;
    out_item_t want;
  } row_t;

  localparam int N_DIRECTED = 25;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_READ,  REG_RATE,     8'h00}, 1'b1, '{RATE_BYTE,   1'b0}},
    '{'{OP_READ,  REG_TAPE,     8'hff}, 1'b1, '{TAPE_BYTE,   1'b0}},
    '{'{OP_READ,  REG_MSR,      8'h00}, 1'b1, '{MSR_READY,   1'b0}},
    '{'{OP_READ,  REG_UNUSED,   8'hff}, 1'b1, '{8'h00,       1'b0}},
    '{'{OP_READ,  REG_NONE,     8'h00}, 1'b1, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_DOR,      8'h0c}, 1'b1, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_FIFO,     8'h10}, 1'b1, '{8'h00,       1'b1}},
    '{'{OP_READ,  REG_MSR,      8'h00}, 1'b1, '{MSR_QUEUED,  1'b0}},
    '{'{OP_READ,  REG_FIFO,     8'h00}, 1'b1, '{VERSION_BYTE, 1'b0}},
    '{'{OP_READ,  REG_STATUS_A, 8'h00}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_STATUS_A, 8'hff}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_READ,  REG_STATUS_A, 8'h00}, 1'b0, '{8'h00,       1'b0}},
    // controller reset and release, which signals an interrupt
    '{'{OP_WRITE, REG_DOR,      8'h00}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_DOR,      8'h0c}, 1'b0, '{8'h00,       1'b0}},
    // seek cut short by a dor write, so the next byte wraps the parameter count
    '{'{OP_WRITE, REG_FIFO,     8'hef}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_DOR,      8'h0c}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_FIFO,     8'h00}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_READ,  REG_MSR,      8'h00}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_RATE,     8'h03}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_RATE,     8'hfc}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_TAPE,     8'hff}, 1'b0, '{8'h00,       1'b0}},
    // unknown command byte
    '{'{OP_WRITE, REG_FIFO,     8'h1f}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_WRITE, REG_FIFO,     8'he8}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_READ,  REG_FIFO,     8'h00}, 1'b0, '{8'h00,       1'b0}},
    '{'{OP_READ,  REG_FIFO,     8'hff}, 1'b0, '{8'h00,       1'b0}}
  };

  localparam cmd_code_t COMMANDS [9] = '{
    CMD_SPECIFY, CMD_SENSE_DRIVE, CMD_READ_DATA, CMD_RECAL, CMD_SENSE_INT,
    CMD_READ_ID, CMD_SEEK, CMD_VERSION, CMD_CONFIGURE
  };

  row_t plan [$];
  out_item_t results_due [$];
  out_item_t predicted;
  int took = 0;
  int sent = 0;
  int fails = 0;
  logic tail = 1'b0;

  // controller state as the predictor sees it
  cmd_state_t fdc_state = '0;
  logic [3:0] params_due = '0;
  logic [2:0] results_queued = '0;
  logic [7:0] cmd_bytes [16] = '{default: 8'h00};
  logic [7:0] head_now = '0;
  logic [7:0] track_now = '0;
  logic [7:0] sector_now = '0;
  logic [7:0] last_sector = '0;
  logic [7:0] status_a = '0;
  logic [7:0] dor_now = '0;
  logic irq_line = 1'b0;
  logic seek_ended = 1'b0;
  logic held_in_reset = 1'b0;
  logic high_density = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  function automatic void raise_irq();
    if (dor_now[3]) irq_line = 1'b1;
    status_a[7] = 1'b1;
  endfunction

  // seven result bytes, read back from index 6 down to 0
  function automatic void load_results(input logic [7:0] sec);
    results_queued = 3'd7;
    cmd_bytes[6] = (seek_ended ? ST0_SEEK_END : 8'h00) | (head_now != 0 ? ST0_HEAD : 8'h00);
    cmd_bytes[5] = 8'h00;
    cmd_bytes[4] = 8'h00;
    cmd_bytes[3] = track_now;
    cmd_bytes[2] = head_now;
    cmd_bytes[1] = sec;
    cmd_bytes[0] = SIZE_CODE;
  endfunction

  function automatic out_item_t fdc_access(input in_item_t a);
    cmd_state_t old;
    logic was_irq;
    logic wr;
    logic [7:0] rd;
    out_item_t r;
    wr = (a.op == OP_WRITE);
    rd = 8'h00;
    if (a.addr == REG_RATE) begin
      if (wr) high_density = (a.wdata[1:0] == 2'b11);
      else rd = RATE_BYTE;
    end else if (a.addr != REG_NONE) begin
      old = fdc_state;
      was_irq = irq_line;
      irq_line = 1'b0;
      fdc_state = '0;
      case (a.addr)
        REG_STATUS_A: if (wr) begin
          status_a = a.wdata;
        end else begin
          rd = status_a | (was_irq ? IRQ_PENDING : 8'h00);
          status_a[7] = 1'b0;
          fdc_state = old;
        end
        REG_DOR: if (wr) begin
          dor_now = a.wdata;
          params_due = '0;
          if (a.wdata[2]) begin
            // leaving controller reset signals an interrupt
            if (held_in_reset) raise_irq();
            else fdc_state = old;
            held_in_reset = 1'b0;
          end else begin
            held_in_reset = 1'b1;
          end
        end else begin
          fdc_state = old;
        end
        REG_TAPE: if (!wr) rd = TAPE_BYTE;
        REG_MSR: if (!wr) begin
          if (old.queue) rd = MSR_QUEUED;
          else rd = MSR_READY | (old.busy ? MSR_BUSY : (old.bytes ? MSR_PARAMS : 8'h00))
                    | (old.dma ? MSR_DMA : 8'h00);
          fdc_state = old;
          fdc_state.busy = 1'b0;
          fdc_state.dma = 1'b0;
        end
        REG_FIFO: if (wr && old.bytes) begin
          params_due = params_due - 4'd1;
          cmd_bytes[params_due] = a.wdata;
          if (params_due != 0) begin
            fdc_state = old;
            fdc_state.busy = 1'b1;
          end else begin
            case (old.code)
              CMD_SEEK: begin
                seek_ended = 1'b1;
                head_now = {7'b0, cmd_bytes[1][1]};
                track_now = cmd_bytes[0];
                cmd_bytes[1] = ST0_SEEK_END;
                cmd_bytes[0] = track_now;
                results_queued = '0;
                fdc_state = {4'b0001, CMD_NONE};
                raise_irq();
              end
              CMD_RECAL: begin
                seek_ended = 1'b1;
                head_now = '0;
                track_now = '0;
                results_queued = '0;
                fdc_state = {4'b0000, CMD_RECAL};
                raise_irq();
              end
              CMD_SPECIFY: begin
                results_queued = '0;
                fdc_state = {4'b0001, CMD_NONE};
                dor_now[3] = cmd_bytes[1][0];
              end
              CMD_SENSE_DRIVE: begin
                results_queued = 3'd1;
                cmd_bytes[0] = ST3_BASE | {5'b0, cmd_bytes[0][2:0]};
                fdc_state = {4'b0100, CMD_SENSE_DRIVE};
              end
              CMD_CONFIGURE: results_queued = '0;
              CMD_READ_ID: begin
                head_now = {7'b0, cmd_bytes[0][2]};
                fdc_state = {4'b0100, CMD_READ_ID};
                load_results(8'd1);
                raise_irq();
              end
              CMD_READ_DATA: begin
                seek_ended = 1'b1;
                fdc_state = {4'b0110, CMD_READ_DATA};
                track_now = cmd_bytes[6];
                head_now = cmd_bytes[5];
                sector_now = cmd_bytes[4];
                last_sector = cmd_bytes[2];
                load_results(sector_now);
                raise_irq();
              end
              default: ;
            endcase
          end
        end else if (wr) begin
          case (cmd_code_t'(a.wdata[4:0]))
            CMD_SPECIFY: begin
              params_due = 4'd2;
              fdc_state = {4'b1001, CMD_SPECIFY};
            end
            CMD_SENSE_DRIVE: begin
              params_due = 4'd1;
              fdc_state = {4'b1001, CMD_SENSE_DRIVE};
            end
            CMD_RECAL: begin
              params_due = 4'd1;
              fdc_state = {4'b1001, CMD_RECAL};
            end
            CMD_SENSE_INT: begin
              params_due = '0;
              results_queued = 3'd2;
              cmd_bytes[1] = ST0_SEEK_END;
              cmd_bytes[0] = track_now;
              seek_ended = 1'b0;
              fdc_state = {4'b0101, CMD_NONE};
            end
            CMD_SEEK: begin
              params_due = 4'd2;
              fdc_state = {4'b1001, CMD_SEEK};
            end
            CMD_VERSION: begin
              results_queued = 3'd1;
              cmd_bytes[0] = VERSION_BYTE;
              fdc_state = {4'b0100, CMD_VERSION};
              raise_irq();
            end
            CMD_CONFIGURE: begin
              params_due = 4'd3;
              fdc_state = {4'b1001, CMD_CONFIGURE};
            end
            CMD_READ_ID: begin
              params_due = 4'd1;
              fdc_state = {4'b1001, CMD_READ_ID};
            end
            CMD_READ_DATA: begin
              params_due = 4'd8;
              fdc_state = {4'b1001, CMD_READ_DATA};
            end
            default: ;
          endcase
        end else if (old.queue) begin
          // the count wraps to seven when read at zero
          results_queued = results_queued - 3'd1;
          rd = cmd_bytes[results_queued];
          if (results_queued != 0) fdc_state = old;
          else if (old.code == CMD_READ_DATA) fdc_state = {4'b0011, CMD_READ_DATA};
          else if (old.code == CMD_SEEK) fdc_state = {4'b0001, CMD_NONE};
        end
        default: ;
      endcase
    end
    r.rdata = wr ? 8'h00 : rd;
    r.irq = irq_line;
    return r;
  endfunction

  function automatic void put(input logic op, input logic [2:0] addr, input logic [7:0] wdata);
    plan.push_back({op, addr, wdata, 1'b0, 9'h000});
  endfunction

  task automatic build_plan();
    int i;
    int j;
    int np;
    int nr;
    cmd_code_t c;
    logic [7:0] b;
    for (i = 0; i < N_DIRECTED; i++) plan.push_back(DIRECTED[i]);
    while (plan.size() < N_DIRECTED + 850) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          c = COMMANDS[$urandom_range(0, 8)];
          case (c)
            CMD_SPECIFY: begin np = 2; nr = 0; end
            CMD_SENSE_DRIVE: begin np = 1; nr = 1; end
            CMD_RECAL: begin np = 1; nr = 0; end
            CMD_SENSE_INT: begin np = 0; nr = 2; end
            CMD_SEEK: begin np = 2; nr = 0; end
            CMD_VERSION: begin np = 0; nr = 1; end
            CMD_CONFIGURE: begin np = 3; nr = 0; end
            CMD_READ_ID: begin np = 1; nr = 7; end
            default: begin np = 8; nr = 7; end
          endcase
          // now and then a sequence broken off early
          if ($urandom_range(0, 7) == 0) begin
            np = $urandom_range(0, np);
            nr = $urandom_range(0, nr);
          end
          put(OP_WRITE, REG_FIFO, {3'($urandom), c});
          for (j = 0; j < np; j++) put(OP_WRITE, REG_FIFO, 8'($urandom));
          if ($urandom_range(0, 2) == 0) put(OP_READ, REG_MSR, 8'($urandom));
          for (j = 0; j < nr; j++) put(OP_READ, REG_FIFO, 8'($urandom));
        end
        6, 7: begin
          // mostly out of reset with the interrupt enabled
          b = 8'($urandom);
          if ($urandom_range(0, 5) != 0) b[2] = 1'b1;
          if ($urandom_range(0, 3) != 0) b[3] = 1'b1;
          put(OP_WRITE, REG_DOR, b);
        end
        default: put(1'($urandom), 3'($urandom), 8'($urandom));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        if (out_data.rdata !== results_due[0].rdata)
          report_mismatch($sformatf("rdata %02h, expected %02h",
                                    out_data.rdata, results_due[0].rdata));
        if (out_data.irq !== results_due[0].irq)
          report_mismatch($sformatf("irq %b, expected %b", out_data.irq, results_due[0].irq));
        void'(results_due.pop_front());
      end
    end
    if (!rst && in_valid && !in_stall) begin
      predicted = fdc_access(in_data);
      results_due.push_back(plan[took].typed ? plan[took].want : predicted);
      took++;
    end
  end

  initial begin : drive
    int k;
    build_plan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < plan.size(); k++) begin
      sent = k;
      tail = (k >= plan.size() - 120);
      if (k == plan.size() / 2) begin
        // sender holds back until every result is out
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= plan[k].acc;
      do @(posedge clk); while (in_stall);
      if (!tail && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : receive
    logic held_long;
    held_long = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_long && sent >= 300) begin
        // long hold-off so the block fills and stalls its input
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (100) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
design/fcf_pkg.sv
design/fcf_in_reg.sv
design/fcf_core.sv
design/fcf_out_reg.sv
design/floppy_controller_command_fifo.sv
verif/tb_top.sv
